FILE: hw/rtl/i2c_seq_pkg.sv
// Shared definitions for the I2C master transfer sequencer: bus action codes,
// command status codes and the packed result layout.
// No dependencies; used by the top level and by its checker.
package i2c_seq_pkg;

  // Next action on the bus, as returned with every result.
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5
  } act_t;

  // Answer to a start command.
  typedef enum logic [1:0] {
    CST_OK     = 2'd0,
    CST_TOOBIG = 2'd1,
    CST_BUSY   = 2'd2
  } cst_t;

  // Result layout, lowest field last so that bus_action sits in the lowest bits.
  typedef struct packed {
    logic [1:0] pad;
    logic [2:0] mode_out;
    logic [7:0] error_code;
    logic       ready_res;
    cst_t       command_status;
    logic [3:0] rx_slot;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] tx_byte;
    act_t       bus_action;
  } res_t;

endpackage

FILE: hw/rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer: decides the next bus action for each command
// or bus status event, with the transmit byte store and a two-deep result buffer.
// Depends on i2c_seq_pkg.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+------------------------------------------
//  in_     | in        | in_tvalid / in_tready | in_tuser = func, in_tdata = operands
//  out_    | out       | out_tvalid/out_tready | out_tdata = action, bytes, status, state
//
// Each input transfer is decided in the cycle it is accepted: the state and the
// result buffer are written at that edge, so one item is taken per cycle while
// in_tready is high, and its result is registered. The transmit byte for the
// next send is prefetched from the store every cycle, so the store's registered
// read port never holds an item back. rst_n is synchronous and active low; it
// clears the sequencing state and both result stages. When the result register
// is full and not taken, one further transfer lands in the skid stage and
// in_tready then drops until the output side moves again.
module i2c_master_transfer_sequencer
  import i2c_seq_pkg::*;
#(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  // [3:0] slot, [11:4] data_byte, [19:12] length, [26:20] device_address,
  // [27] rep_start, [35:28] bus_status, [39:36] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] bus_action, [10:3] tx_byte, [11] rx_valid, [19:12] rx_byte,
  // [23:20] rx_slot, [25:24] command_status, [26] ready_res,
  // [34:27] error_code, [37:35] mode_out, [39:38] zero
  output logic [39:0] out_tdata
);

  // Store address, transmit count and receive count widths.
  localparam int AW = $clog2(TX_DEPTH);
  localparam int CW = $clog2(TX_DEPTH + 1);
  localparam int RW = $clog2(RX_DEPTH + 1);

  // Item kinds carried in in_tuser.
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;
  localparam logic [1:0] FN_EVENT = 2'd3;

  // Bus status codes after masking off the low three bits.
  localparam logic [7:0] ST_ILLEGAL  = 8'h00;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_REPSTART = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK = 8'h18;
  localparam logic [7:0] ST_SLAW_NAK = 8'h20;
  localparam logic [7:0] ST_DATW_ACK = 8'h28;
  localparam logic [7:0] ST_DATW_NAK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK = 8'h40;
  localparam logic [7:0] ST_SLAR_NAK = 8'h48;
  localparam logic [7:0] ST_DATR_ACK = 8'h50;
  localparam logic [7:0] ST_DATR_NAK = 8'h58;
  localparam logic [7:0] ST_MASK     = 8'hF8;

  localparam logic [7:0] ERR_NONE    = 8'hFF;
  localparam logic [7:0] ERR_BUSY    = 8'hF8;

  typedef enum logic [2:0] {
    MODE_READY   = 3'd0,
    MODE_INIT    = 3'd1,
    MODE_REPSENT = 3'd2,
    MODE_TX      = 3'd3,
    MODE_RX      = 3'd4
  } mode_t;

  // Input fields.
  logic [1:0] func;
  logic [3:0] slot;
  logic [7:0] data_byte;
  logic [7:0] length;
  logic [6:0] device_address;
  logic       rep_start;
  logic [7:0] st;

  assign func           = in_tuser;
  assign slot           = in_tdata[3:0];
  assign data_byte      = in_tdata[11:4];
  assign length         = in_tdata[19:12];
  assign device_address = in_tdata[26:20];
  assign rep_start      = in_tdata[27];
  assign st             = in_tdata[35:28] & ST_MASK;

  // Sequencing state.
  mode_t          mode_r, mode_nxt;
  logic [7:0]     last_err_r, last_err_nxt;
  logic           hold_r, hold_nxt;
  logic [CW-1:0]  tx_count_r, tx_count_nxt;
  logic [CW-1:0]  tx_pos_r, tx_pos_nxt;
  logic [RW-1:0]  rx_count_r, rx_count_nxt;
  logic [RW-1:0]  rx_pos_r, rx_pos_nxt;

  // Result buffer: output register plus one skid stage.
  logic           out_v_r, out_v_nxt;
  res_t           out_d_r, out_d_nxt;
  logic           skid_v_r, skid_v_nxt;
  res_t           skid_d_r, skid_d_nxt;
  logic           in_rdy_r;

  // Transmit store with a registered, write-through read port. Slot 0 is also
  // kept in a register because a start after a repeated start sends it at once.
  logic [7:0]     tx_mem [TX_DEPTH];
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [7:0]     mem_wd;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_q;
  logic [7:0]     slot0_r;

  logic           in_acc;
  res_t           res;

  logic [AW+3:0]  slot_ext;
  logic           slot_ok;
  logic           ready_now;
  logic           rx_cap;
  logic [RW-1:0]  rx_pos_cap;
  logic [RW+3:0]  rx_pos_ext;
  logic [7:0]     addr_byte;
  act_t           ack_act;

  assign in_acc    = in_tvalid && in_rdy_r;
  assign in_tready = in_rdy_r;

  assign slot_ext  = {{AW{1'b0}}, slot};
  assign slot_ok   = slot_ext < (AW + 4)'(TX_DEPTH);
  assign ready_now = (mode_r == MODE_READY) || (mode_r == MODE_REPSENT);
  assign addr_byte = {device_address, 1'b1};

  // A received byte is captured while there is room in the receive window.
  assign rx_cap     = (func == FN_EVENT) && ((st == ST_DATR_ACK) || (st == ST_DATR_NAK)) &&
                      ((RW + 1)'(rx_pos_r) < (RW + 1)'(RX_DEPTH));
  assign rx_pos_cap = rx_cap ? rx_pos_r + RW'(1) : rx_pos_r;
  assign rx_pos_ext = {4'd0, rx_pos_r};

  // Acknowledge while more bytes are still due after this one.
  assign ack_act = (((RW + 1)'(rx_pos_cap) + (RW + 1)'(1)) < (RW + 1)'(rx_count_r)) ?
                   ACT_ACK : ACT_NACK;

  always_comb begin
    mode_nxt     = mode_r;
    last_err_nxt = last_err_r;
    hold_nxt     = hold_r;
    tx_count_nxt = tx_count_r;
    tx_pos_nxt   = tx_pos_r;
    rx_count_nxt = rx_count_r;
    rx_pos_nxt   = rx_pos_r;
    mem_we       = 1'b0;
    mem_wa       = slot_ext[AW-1:0];
    mem_wd       = data_byte;
    res          = '0;

    if (in_acc) begin
      case (func)
        FN_LOAD: begin
          mem_we = slot_ok;
        end
        FN_WRITE: begin
          if ({1'b0, length} > 9'(TX_DEPTH)) begin
            res.command_status = CST_TOOBIG;
          end else if (!ready_now) begin
            res.command_status = CST_BUSY;
          end else begin
            hold_nxt     = rep_start;
            tx_count_nxt = CW'(length);
            mode_nxt     = MODE_INIT;
            if (mode_r == MODE_REPSENT) begin
              res.tx_byte    = slot0_r;
              res.bus_action = ACT_SEND;
              tx_pos_nxt     = CW'(1);
            end else begin
              res.bus_action = ACT_START;
              tx_pos_nxt     = '0;
            end
          end
        end
        FN_READ: begin
          if ({1'b0, length} >= 9'(RX_DEPTH)) begin
            res.command_status = CST_TOOBIG;
          end else if (!ready_now) begin
            res.command_status = CST_BUSY;
          end else begin
            // The read address goes out as a one-byte write from slot 0.
            rx_pos_nxt   = '0;
            rx_count_nxt = RW'(length);
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd       = addr_byte;
            hold_nxt     = rep_start;
            tx_count_nxt = CW'(1);
            mode_nxt     = MODE_INIT;
            if (mode_r == MODE_REPSENT) begin
              res.tx_byte    = addr_byte;
              res.bus_action = ACT_SEND;
              tx_pos_nxt     = CW'(1);
            end else begin
              res.bus_action = ACT_START;
              tx_pos_nxt     = '0;
            end
          end
        end
        default: begin
          if (rx_cap) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = data_byte;
            res.rx_slot  = rx_pos_ext[3:0];
          end
          rx_pos_nxt = rx_pos_cap;
          case (st)
            ST_START, ST_SLAW_ACK, ST_DATW_ACK: begin
              if (st == ST_SLAW_ACK) begin
                mode_nxt = MODE_TX;
              end
              if (tx_pos_r < tx_count_r) begin
                res.tx_byte    = rd_q;
                res.bus_action = ACT_SEND;
                tx_pos_nxt     = tx_pos_r + CW'(1);
                last_err_nxt   = ERR_BUSY;
              end else begin
                last_err_nxt = ERR_NONE;
                if (hold_r) begin
                  res.bus_action = ACT_START;
                end else begin
                  res.bus_action = ACT_STOP;
                  mode_nxt       = MODE_READY;
                end
              end
            end
            ST_SLAR_ACK: begin
              mode_nxt       = MODE_RX;
              last_err_nxt   = ERR_BUSY;
              res.bus_action = ack_act;
            end
            ST_DATR_ACK: begin
              last_err_nxt   = ERR_BUSY;
              res.bus_action = ack_act;
            end
            ST_DATR_NAK, ST_SLAW_NAK, ST_DATW_NAK, ST_ARB_LOST, ST_SLAR_NAK: begin
              last_err_nxt = (st == ST_DATR_NAK) ? ERR_NONE : st;
              if (hold_r) begin
                res.bus_action = ACT_START;
              end else begin
                res.bus_action = ACT_STOP;
                mode_nxt       = MODE_READY;
              end
            end
            ST_REPSTART: begin
              mode_nxt = MODE_REPSENT;
            end
            ST_ILLEGAL: begin
              last_err_nxt   = ST_ILLEGAL;
              mode_nxt       = MODE_READY;
              res.bus_action = ACT_STOP;
            end
            default: begin
            end
          endcase
        end
      endcase
    end

    res.ready_res  = (mode_nxt == MODE_READY) || (mode_nxt == MODE_REPSENT);
    res.error_code = last_err_nxt;
    res.mode_out   = 3'(mode_nxt);
    res.pad        = '0;
  end

  // Prefetch the store entry at the next send position every cycle.
  assign rd_addr = tx_pos_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[mem_wa] <= mem_wd;
    end
    rd_q <= (mem_we && (mem_wa == rd_addr)) ? mem_wd : tx_mem[rd_addr];
    if (mem_we && (mem_wa == '0)) begin
      slot0_r <= mem_wd;
    end
  end

  // Result buffer: the skid stage only fills when the output register is held.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_v_r || out_tready) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_READY;
      last_err_r <= ERR_NONE;
      hold_r     <= 1'b0;
      tx_count_r <= '0;
      tx_pos_r   <= '0;
      rx_count_r <= '0;
      rx_pos_r   <= '0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
      in_rdy_r   <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      last_err_r <= last_err_nxt;
      hold_r     <= hold_nxt;
      tx_count_r <= tx_count_nxt;
      tx_pos_r   <= tx_pos_nxt;
      rx_count_r <= rx_count_nxt;
      rx_pos_r   <= rx_pos_nxt;
      out_v_r    <= out_v_nxt;
      skid_v_r   <= skid_v_nxt;
      in_rdy_r   <= !skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

FILE: hw/rtl/i2c_seq_checker.sv
// Port-level checks for the I2C master transfer sequencer, attached by bind.
// Depends on i2c_seq_pkg and on the top level's port names.
module i2c_seq_checker
  import i2c_seq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  res_t res;
  assign res = out_tdata;

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An accepted transfer with room at the output shows a result next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (!out_tvalid || out_tready) |=> out_tvalid)
    else $error("accepted transfer produced no result");

  // The input side only stalls while a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && $past(rst_n) |-> out_tvalid)
    else $error("input stalled with empty output");

  // A rejected start drives nothing on the bus.
  a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.command_status != CST_OK) |-> res.bus_action == ACT_NONE)
    else $error("rejected start produced a bus action");

  // Receive fields are zero unless a byte was captured.
  a_rx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.rx_valid |-> (res.rx_byte == 8'd0) && (res.rx_slot == 4'd0))
    else $error("stale receive fields");

endmodule

bind i2c_master_transfer_sequencer i2c_seq_checker u_i2c_seq_checker (.*);

FILE: tb/sv/tb_i2c_master_transfer_sequencer.sv
// Self-checking testbench for the I2C master transfer sequencer: directed and random command
// and bus status streams, each result checked against a cycle-free model of the sequencing rules.
// Depends on i2c_seq_pkg and i2c_master_transfer_sequencer.
module tb_i2c_master_transfer_sequencer;
  import i2c_seq_pkg::*;

  localparam int TX_DEPTH   = 16;
  localparam int RX_DEPTH   = 16;
  localparam int RAND_ITEMS = 1650;
  // Longest legal silence: a receiver hold of HOLD_LEN plus a full pipeline refill, with margin.
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;

  // Item kinds carried on in_tuser.
  typedef enum logic [1:0] {
    FN_LOAD_TX     = 2'd0,
    FN_START_WRITE = 2'd1,
    FN_START_READ  = 2'd2,
    FN_BUS_EVENT   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_READY    = 3'd0,
    MODE_INIT     = 3'd1,
    MODE_REP_SENT = 3'd2,
    MODE_TX       = 3'd3,
    MODE_RX       = 3'd4
  } mode_t;

  // Bus status codes, upper five bits only.
  localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_REP_START  = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;
  localparam logic [7:0] ST_NO_INFO    = 8'hF8;
  localparam logic [7:0] ST_CODE_MASK  = 8'hF8;

  localparam logic [7:0] ERR_NONE        = 8'hFF;
  localparam logic [7:0] ERR_IN_PROGRESS = 8'hF8;

  // One command or bus event, plus a flag that makes the sender wait for every
  // outstanding result before offering it.
  typedef struct packed {
    func_t      func;
    logic [3:0] slot;
    logic [7:0] data_byte;
    logic [7:0] length;
    logic [6:0] addr;
    logic       rep;
    logic [7:0] status;
    logic       drain;
  } seq_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  // Commands still to be offered, and results owed by the block, oldest first.
  seq_cmd_t cmd_backlog[$];
  res_t     due_results[$];

  // Model state of the sequencer.
  mode_t      mode;
  logic [7:0] last_err;
  logic       hold_bus;
  logic [7:0] tx_mem [TX_DEPTH];
  logic [4:0] tx_len;
  logic [4:0] tx_idx;
  logic [7:0] rx_len;
  logic [4:0] rx_idx;

  // Bookkeeping shared between the clocked processes.
  bit          in_taken;
  bit          out_taken;
  bit          drain_next;
  int unsigned fail_cnt;
  int unsigned res_cnt;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned next_hold_at = 300;
  logic [9:0]  stall_phase;
  res_t        want;
  res_t        got;

  i2c_master_transfer_sequencer #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencing model
  // ---------------------------------------------------------------------------

  // A new frame may only be opened when the bus is idle or held by a repeated start.
  function automatic bit bus_free();
    return mode == MODE_READY || mode == MODE_REP_SENT;
  endfunction

  // Opens a frame of n stored bytes. With a repeated start already on the bus the
  // START is skipped and slot 0 goes out straight away, whatever the length.
  function automatic act_t open_frame(input logic [4:0] n, input logic rep,
                                      output logic [7:0] first);
    hold_bus = rep;
    tx_len   = n;
    tx_idx   = '0;
    first    = '0;
    if (mode == MODE_REP_SENT) begin
      mode   = MODE_INIT;
      first  = tx_mem[0];
      tx_idx = 5'd1;
      return ACT_SEND;
    end
    mode = MODE_INIT;
    return ACT_START;
  endfunction

  // End of a frame: keep the bus with a fresh START when holding, otherwise release it.
  function automatic act_t close_frame(input logic [7:0] err);
    last_err = err;
    if (hold_bus) return ACT_START;
    mode = MODE_READY;
    return ACT_STOP;
  endfunction

  // Acknowledge while more bytes are wanted; the last wanted byte (or any byte of
  // an empty read) is answered with a nack.
  function automatic act_t rx_answer();
    last_err = ERR_IN_PROGRESS;
    return (rx_idx + 1 < rx_len) ? ACT_ACK : ACT_NACK;
  endfunction

  function automatic res_t next_action(input seq_cmd_t c);
    res_t       r;
    logic [7:0] st;
    logic [7:0] first;
    r     = '0;
    first = '0;
    st    = c.status & ST_CODE_MASK;
    case (c.func)
      FN_LOAD_TX: tx_mem[c.slot] = c.data_byte;
      FN_START_WRITE: begin
        if (c.length > TX_DEPTH) r.command_status = CST_TOOBIG;
        else if (!bus_free()) r.command_status = CST_BUSY;
        else r.bus_action = open_frame(c.length[4:0], c.rep, first);
      end
      FN_START_READ: begin
        if (c.length >= RX_DEPTH) r.command_status = CST_TOOBIG;
        else if (!bus_free()) r.command_status = CST_BUSY;
        else begin
          // The address byte is written into slot 0 and sent as a one-byte frame.
          rx_idx    = '0;
          rx_len    = c.length;
          tx_mem[0] = {c.addr, 1'b1};
          r.bus_action = open_frame(5'd1, c.rep, first);
        end
      end
      default: begin
        // Received bytes are captured before the status decides the next step;
        // once the receive store is full they are dropped silently.
        if ((st == ST_RX_ACK || st == ST_RX_NACK) && rx_idx < RX_DEPTH) begin
          r.rx_valid = 1'b1;
          r.rx_byte  = c.data_byte;
          r.rx_slot  = rx_idx[3:0];
          rx_idx     = rx_idx + 5'd1;
        end
        case (st)
          ST_START, ST_SLAW_ACK, ST_DATA_ACK: begin
            if (st == ST_SLAW_ACK) mode = MODE_TX;
            if (tx_idx < tx_len) begin
              first        = tx_mem[tx_idx[3:0]];
              tx_idx       = tx_idx + 5'd1;
              last_err     = ERR_IN_PROGRESS;
              r.bus_action = ACT_SEND;
            end else begin
              r.bus_action = close_frame(ERR_NONE);
            end
          end
          ST_SLAR_ACK: begin
            mode         = MODE_RX;
            r.bus_action = rx_answer();
          end
          ST_RX_ACK:  r.bus_action = rx_answer();
          ST_RX_NACK: r.bus_action = close_frame(ERR_NONE);
          ST_SLAW_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLAR_NACK:
            r.bus_action = close_frame(st);
          ST_REP_START: mode = MODE_REP_SENT;
          ST_BUS_ERROR: begin
            last_err     = 8'h00;
            mode         = MODE_READY;
            r.bus_action = ACT_STOP;
          end
          default: ;
        endcase
      end
    endcase
    r.tx_byte    = first;
    r.ready_res  = bus_free();
    r.error_code = last_err;
    r.mode_out   = mode;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      fail_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Every field random, so that the fields an item kind ignores still toggle.
  function automatic seq_cmd_t rand_cmd();
    seq_cmd_t c;
    c.func      = func_t'($urandom_range(0, 3));
    c.slot      = 4'($urandom);
    c.data_byte = 8'($urandom);
    c.length    = 8'($urandom);
    c.addr      = 7'($urandom);
    c.rep       = 1'($urandom);
    c.status    = 8'($urandom);
    c.drain     = drain_next;
    drain_next  = 1'b0;
    return c;
  endfunction

  task automatic push_load(input logic [3:0] slot, input logic [7:0] data);
    seq_cmd_t c;
    c           = rand_cmd();
    c.func      = FN_LOAD_TX;
    c.slot      = slot;
    c.data_byte = data;
    cmd_backlog.push_back(c);
  endtask

  task automatic push_start(input func_t f, input logic [7:0] len, input logic [6:0] addr,
                            input logic rep);
    seq_cmd_t c;
    c        = rand_cmd();
    c.func   = f;
    c.length = len;
    c.addr   = addr;
    c.rep    = rep;
    cmd_backlog.push_back(c);
  endtask

  // The three low status bits are don't-care and are filled at random.
  task automatic push_bus(input logic [7:0] st);
    seq_cmd_t c;
    c        = rand_cmd();
    c.func   = FN_BUS_EVENT;
    c.status = st | 8'($urandom_range(0, 7));
    cmd_backlog.push_back(c);
  endtask

  initial begin
    int   kind;
    int   len;
    int   n_ev;
    int   fail_at;
    int   nb;
    int   seq_no;
    int   base;
    logic rep;
    bit   from_rep;
    bit   cut;

    // Directed part. Every transmit slot is written first, so no later frame can
    // ever send a slot that was never loaded.
    for (int i = 0; i < TX_DEPTH; i++)
      push_load(4'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
    push_start(FN_START_WRITE, 8'd17, 7'($urandom), 1'b0);  // write one byte too long
    push_start(FN_START_READ, 8'd16, 7'($urandom), 1'b0);   // read one byte too long
    push_start(FN_START_WRITE, 8'd2, 7'($urandom), 1'b1);   // two bytes, hold the bus
    push_start(FN_START_READ, 8'd0, 7'($urandom), 1'b0);    // refused while busy
    push_bus(ST_START);
    push_bus(ST_SLAW_ACK);
    push_bus(ST_DATA_ACK);                                  // frame done, repeated START
    push_bus(ST_REP_START);
    push_start(FN_START_READ, 8'd0, 7'h7F, 1'b0);           // address byte goes out at once
    push_bus(ST_SLAR_ACK);                                  // empty read answers nack
    push_bus(ST_RX_NACK);
    push_bus(ST_NO_INFO);
    push_bus(ST_BUS_ERROR);
    push_bus(ST_ARB_LOST);

    // Random part: mostly well-formed frames with random content, some overrunning
    // reads, bursts of noise (each followed by a bus error that returns to idle)
    // and stray loads. The first random item waits for the pipeline to drain.
    base     = cmd_backlog.size();
    from_rep = 1'b0;
    seq_no   = 0;
    while (cmd_backlog.size() - base < RAND_ITEMS) begin
      if (seq_no % 40 == 0) drain_next = 1'b1;
      seq_no++;
      kind = $urandom_range(0, 9);
      rep  = ($urandom_range(0, 2) == 0);
      if (kind <= 3) begin
        len = ($urandom_range(0, 3) == 0) ? TX_DEPTH : $urandom_range(0, TX_DEPTH);
        push_start(FN_START_WRITE, 8'(len), 7'($urandom), rep);
        // After a repeated start slot 0 is already on the bus, so one event fewer, save for an empty frame.
        n_ev    = from_rep ? ((len == 0) ? 1 : len) : len + 1;
        fail_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_ev - 1) : n_ev;
        cut     = 1'b0;
        for (int k = 0; k < n_ev && !cut; k++) begin
          if (k == fail_at) begin
            case ($urandom_range(0, 2))
              0:       push_bus(ST_SLAW_NACK);
              1:       push_bus(ST_DATA_NACK);
              default: push_bus(ST_ARB_LOST);
            endcase
            cut = 1'b1;
          end else if (k == 0) begin
            push_bus(from_rep ? ST_SLAW_ACK : ST_START);
          end else if (k == 1 && !from_rep) begin
            push_bus(ST_SLAW_ACK);
          end else begin
            push_bus(ST_DATA_ACK);
          end
        end
      end else if (kind <= 7) begin
        len = ($urandom_range(0, 3) == 0) ? RX_DEPTH - 1 : $urandom_range(0, RX_DEPTH - 1);
        push_start(FN_START_READ, 8'(len), 7'($urandom), rep);
        if (!from_rep) push_bus(ST_START);
        if ($urandom_range(0, 5) == 0) begin
          push_bus(ST_SLAR_NACK);
        end else begin
          push_bus(ST_SLAR_ACK);
          // An overrunning read sends more bytes than the receive store can hold.
          nb = (kind == 7) ? $urandom_range(RX_DEPTH + 1, RX_DEPTH + 4)
                           : ((len == 0) ? 1 : len);
          for (int k = 1; k < nb; k++) push_bus(ST_RX_ACK);
          push_bus(ST_RX_NACK);
        end
      end else if (kind == 8) begin
        n_ev = $urandom_range(1, 8);
        for (int k = 0; k < n_ev; k++) cmd_backlog.push_back(rand_cmd());
        push_bus(ST_BUS_ERROR);
        rep      = 1'b0;
        from_rep = 1'b0;
      end else begin
        n_ev = $urandom_range(1, 4);
        for (int k = 0; k < n_ev; k++) push_load(4'($urandom), 8'($urandom));
      end
      // A held bus is normally followed by the repeated start; now and then the
      // line breaks instead and the block falls back to idle.
      if (kind <= 7) begin
        if (!rep) begin
          from_rep = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          push_bus(ST_BUS_ERROR);
          from_rep = 1'b0;
        end else begin
          push_bus(ST_REP_START);
          from_rep = 1'b1;
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Everything offered and every result in; then a final wait to catch strays.
    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog in bursts with random gaps. A transfer on offer is
  // held unchanged until it is taken; an item marked for draining waits until no
  // result is owed any more.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_tvalid && !in_taken) begin
      // Still waiting for the block to take the current transfer.
    end else if (gap_left > 0) begin
      gap_left--;
      in_tvalid <= 1'b0;
    end else if (cmd_backlog.size() == 0 ||
                 (cmd_backlog[0].drain && due_results.size() != 0)) begin
      in_tvalid <= 1'b0;
    end else begin
      in_tvalid <= 1'b1;
      in_tuser  <= cmd_backlog[0].func;
      in_tdata  <= {4'b0, cmd_backlog[0].status, cmd_backlog[0].rep, cmd_backlog[0].addr,
                    cmd_backlog[0].length, cmd_backlog[0].data_byte, cmd_backlog[0].slot};
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // Half of the bursts run straight into the next one.
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
      end
    end
  end

  // Receiver: a stall pattern that changes character with stall_phase[9:8], and every
  // 900 results a long hold so that both result stages fill and in_tready drops.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 10'd1;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (res_cnt >= next_hold_at) begin
      hold_left    = HOLD_LEN;
      next_hold_at = next_hold_at + 900;
      out_tready   <= 1'b0;
    end else begin
      case (stall_phase[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= (stall_phase[2:0] < 3'd5);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial stall_phase = '0;

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest expectation, then
  // predicts the result of any input transfer taken at the same edge. It also
  // keeps the watchdog on cycles in which neither side moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_taken = rst_n && out_tvalid && out_tready;
    in_taken  = rst_n && in_tvalid && in_tready;
    if (out_taken) begin
      got = out_tdata;
      if (due_results.size() == 0) begin
        $display("%0t: result expected none, got 0x%010h", $time, out_tdata);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("bus_action", want.bus_action, got.bus_action);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("rx_valid", want.rx_valid, got.rx_valid);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("rx_slot", want.rx_slot, got.rx_slot);
        check_field("command_status", want.command_status, got.command_status);
        check_field("ready_res", want.ready_res, got.ready_res);
        check_field("error_code", want.error_code, got.error_code);
        check_field("mode_out", want.mode_out, got.mode_out);
        check_field("padding", 0, got.pad);
      end
      res_cnt++;
    end
    if (in_taken) due_results.push_back(next_action(cmd_backlog.pop_front()));
    if (in_taken || out_taken) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The model leaves reset in the same state as the block.
  initial begin
    mode     = MODE_READY;
    last_err = ERR_NONE;
    hold_bus = 1'b0;
    tx_len   = '0;
    tx_idx   = '0;
    rx_len   = '0;
    rx_idx   = '0;
  end

endmodule
